// ===== rtl/icfb_pkg.sv =====
// ----------------------------------------------------------------------------
// icfb_pkg
// shared types, codes and helpers for the byte-wide idea cfb stream block
// ----------------------------------------------------------------------------
package icfb_pkg;

    localparam int ROUND_COUNT = 8;
    localparam int BLOCK_W     = 64;
    localparam int KEY_W       = 128;
    localparam int WORD_W      = 16;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [KEY_W-1:0]   key_t;

    typedef enum logic [1:0] {
        REG_KEY_HIGH  = 2'd0,
        REG_KEY_LOW   = 2'd1,
        REG_IV        = 2'd2,
        REG_DECRYPT   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WAIT = 2'b10
    } top_state_t;

    typedef enum logic [1:0] {
        E_IDLE = 2'b01,
        E_RUN  = 2'b10
    } eng_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_stat_t;

    // read byte p of the block, byte 0 in the top bits
    function automatic logic [7:0] blk_byte(input block_t b, input logic [2:0] p);
        return b[{~p, 3'b000} +: 8];
    endfunction

    // replace byte p of the block
    function automatic block_t blk_put(input block_t b, input logic [2:0] p,
                                       input logic [7:0] v);
        block_t r;
        r = b;
        r[{~p, 3'b000} +: 8] = v;
        return r;
    endfunction

endpackage

// ===== rtl/icfb_mulmod.sv =====
// ----------------------------------------------------------------------------
// icfb_mulmod
// multiplication modulo 65537, a zero operand stands for 65536
// ----------------------------------------------------------------------------
module icfb_mulmod (
    input  icfb_pkg::word_t a,
    input  icfb_pkg::word_t b,
    output icfb_pkg::word_t p
);
    import icfb_pkg::*;

    logic [31:0] prod;
    word_t       lo;
    word_t       hi;

    assign prod = {16'd0, a} * {16'd0, b};
    assign lo   = prod[15:0];
    assign hi   = prod[31:16];

    always_comb
    begin
        if (prod != 32'd0)
        begin
            p = lo - hi + {15'd0, (lo < hi)};
        end
        else
        begin
            p = 16'd1 - a - b;
        end
    end

endmodule

// ===== rtl/icfb_engine.sv =====
// ----------------------------------------------------------------------------
// icfb_engine
// block encryption, one subkey step per cycle over a shared modular multiplier
// ----------------------------------------------------------------------------
module icfb_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  icfb_pkg::key_t     key,
    input  icfb_pkg::block_t   blk_in,
    output icfb_pkg::block_t   blk_out,
    output icfb_pkg::eng_stat_t stat
);
    import icfb_pkg::*;

    eng_state_t state_reg, state_next;
    word_t x1_reg, x2_reg, x3_reg, x4_reg, t3_reg;
    key_t  kw_reg;
    logic [2:0] w_reg;
    logic [2:0] phase_reg;
    logic [3:0] round_reg;
    logic       done_reg;

    word_t sub;
    word_t mul_a;
    word_t mul_p;
    word_t sum;
    logic  final_rnd;

    assign sub       = kw_reg[{~w_reg, 4'b0000} +: 16];
    assign final_rnd = (round_reg == 4'(ROUND_COUNT));
    assign sum       = t3_reg + mul_p;

    always_comb
    begin
        case (phase_reg)
            3'd0:    mul_a = x1_reg;
            3'd3:    mul_a = x4_reg;
            3'd4:    mul_a = x3_reg ^ x1_reg;
            3'd5:    mul_a = (x2_reg ^ x4_reg) + t3_reg;
            default: mul_a = x1_reg;
        endcase
    end

    icfb_mulmod u_mul (
        .a (mul_a),
        .b (sub),
        .p (mul_p)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE:  if (start) state_next = E_RUN;
            E_RUN:   if (final_rnd && phase_reg == 3'd3) state_next = E_IDLE;
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
            phase_reg <= 3'd0;
            round_reg <= 4'd0;
            w_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == E_RUN) && final_rnd && (phase_reg == 3'd3);
            if (state_reg == E_IDLE)
            begin
                phase_reg <= 3'd0;
                round_reg <= 4'd0;
                w_reg     <= 3'd0;
            end
            else
            begin
                w_reg <= w_reg + 3'd1;
                if (phase_reg == 3'd5)
                begin
                    phase_reg <= 3'd0;
                    round_reg <= round_reg + 4'd1;
                end
                else
                begin
                    phase_reg <= phase_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == E_IDLE)
        begin
            if (start)
            begin
                x1_reg <= blk_in[63:48];
                x2_reg <= blk_in[47:32];
                x3_reg <= blk_in[31:16];
                x4_reg <= blk_in[15:0];
                kw_reg <= key;
            end
        end
        else
        begin
            // key rotates by 25 after every eighth subkey
            if (w_reg == 3'd7)
            begin
                kw_reg <= {kw_reg[102:0], kw_reg[127:103]};
            end
            case (phase_reg)
                3'd0: x1_reg <= mul_p;
                3'd1:
                begin
                    if (final_rnd)
                    begin
                        x2_reg <= x3_reg + sub;
                        x3_reg <= x2_reg;
                    end
                    else
                    begin
                        x2_reg <= x2_reg + sub;
                    end
                end
                3'd2: x3_reg <= x3_reg + sub;
                3'd3: x4_reg <= mul_p;
                3'd4: t3_reg <= mul_p;
                3'd5:
                begin
                    x1_reg <= x1_reg ^ mul_p;
                    x4_reg <= x4_reg ^ sum;
                    x2_reg <= mul_p ^ x3_reg;
                    x3_reg <= sum ^ x2_reg;
                end
                default: x1_reg <= x1_reg;
            endcase
        end
    end

    assign blk_out   = {x1_reg, x2_reg, x3_reg, x4_reg};
    assign stat.busy = (state_reg == E_RUN);
    assign stat.done = done_reg;

endmodule

// ===== rtl/idea_cfb_byte_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// idea_cfb_byte_stream_cipher
// byte-wide idea cipher feedback stream with on-the-fly subkey generation
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  input     in         in_valid, in_stall, data_byte
//  output    out        out_valid, out_stall, result_byte
//  config    in         cfg_we, cfg_index, cfg_data
//
//  a word at position 0..7 goes straight into the output register when accepted
//  a word that needs a fresh block waits for 52 subkey steps on the
//  shared modular multiplier and then for the merge of the fresh block
//  in_stall is high while the block is encrypted and while a result is held
//  under out_stall; reset clears key, iv, mode and position to zero
// ----------------------------------------------------------------------------
module idea_cfb_byte_stream_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  result_byte,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import icfb_pkg::*;

    top_state_t state_reg, state_next;
    logic [63:0] key_hi_reg, key_lo_reg;
    block_t      block_reg;
    logic [3:0]  pos_reg;
    logic        mode_reg;
    logic [7:0]  data_reg;
    logic        out_valid_reg;
    logic [7:0]  result_reg;

    logic        accept;
    logic        start;
    logic        out_load;
    block_t      eng_blk;
    eng_stat_t   eng_stat;
    logic [7:0]  cur_in, res_in, res_new, fb_new;

    assign in_stall = !((state_reg == S_IDLE) && (!out_valid_reg || !out_stall));
    assign accept   = in_valid && !in_stall;
    assign start    = accept && pos_reg[3];
    assign out_load = !cfg_we && ((accept && !pos_reg[3]) ||
                                  (state_reg == S_WAIT && eng_stat.done));

    icfb_engine u_eng (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .key     ({key_hi_reg, key_lo_reg}),
        .blk_in  (block_reg),
        .blk_out (eng_blk),
        .stat    (eng_stat)
    );

    assign cur_in  = blk_byte(block_reg, pos_reg[2:0]);
    assign res_in  = data_byte ^ cur_in;
    assign res_new = data_reg ^ eng_blk[63:56];
    assign fb_new  = mode_reg ? data_reg : res_new;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_WAIT;
            S_WAIT:  if (eng_stat.done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_hi_reg    <= '0;
            key_lo_reg    <= '0;
            block_reg     <= '0;
            pos_reg       <= 4'd0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_HIGH: key_hi_reg <= cfg_data;
                    REG_KEY_LOW:  key_lo_reg <= cfg_data;
                    REG_IV:
                    begin
                        block_reg <= cfg_data;
                        pos_reg   <= 4'd0;
                    end
                    REG_DECRYPT:  mode_reg <= cfg_data[0];
                    default:      mode_reg <= mode_reg;
                endcase
            end
            else if (accept && !pos_reg[3])
            begin
                block_reg     <= blk_put(block_reg, pos_reg[2:0],
                                         mode_reg ? data_byte : res_in);
                pos_reg       <= pos_reg + 4'd1;
            end
            else if (state_reg == S_WAIT && eng_stat.done)
            begin
                // fresh block, first byte goes out at once
                block_reg     <= {fb_new, eng_blk[55:0]};
                pos_reg       <= 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            data_reg <= data_byte;
        end
        if (accept && !pos_reg[3])
        begin
            result_reg <= res_in;
        end
        else if (state_reg == S_WAIT && eng_stat.done)
        begin
            result_reg <= res_new;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_byte = result_reg;

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 4'd8)
        else $error("byte position beyond eight");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        eng_stat.done |-> (state_reg == S_WAIT))
        else $error("engine done outside wait");

    a_wait_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> (in_stall && eng_stat.busy != eng_stat.done))
        else $error("input open or engine idle during block encryption");

    a_direct_out: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !pos_reg[3] && !cfg_we) |=> out_valid_reg)
        else $error("accepted word gave no result");
`endif

endmodule
